// ----- rtl/core/mks_pkg.sv -----
// Package for the matrix keypad scanner core: payload widths, scan modes,
// configuration register indexes, state and result structs and the key map.
// No dependencies.
package mks_pkg;

   localparam int unsigned BTN_W   = 7;
   localparam int unsigned COL_W   = 4;
   localparam int unsigned ROW_W   = 4;
   localparam int unsigned CODE_W  = 5;
   localparam int unsigned TICK_W  = 6;
   localparam int unsigned IDX_W   = 2;
   localparam int unsigned HELD_W  = 3;
   localparam int unsigned REQ_W   = 16;
   localparam int unsigned RSP_W   = 16;

   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 6'd25;
   localparam logic [TICK_W-1:0] RELEASE_RESET  = 6'd30;
   localparam logic [CODE_W-1:0] DIRECT_BASE    = 5'd16;
   localparam logic [HELD_W-1:0] HELD_NONE      = 3'd7;
   localparam logic [HELD_W-1:0] HELD_LAST      = 3'd6;
   localparam logic [COL_W-1:0]  COL_IDLE       = 4'hF;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_RELEASE  = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_DDEB    = 5'b00010,
      MODE_DHELD   = 5'b00100,
      MODE_MDEB    = 5'b01000,
      MODE_RELWAIT = 5'b10000
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [IDX_W-1:0]   row;
      logic [TICK_W-1:0]  wait_cnt;
      logic               locked;
      logic [HELD_W-1:0]  held;
   } scan_state_type;

   typedef struct packed {
      logic [CODE_W-1:0]  key_id;
      logic               key_valid;
      logic [ROW_W-1:0]   row_drive;
   } result_type;

   function automatic logic [CODE_W-1:0] key_lookup(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
      logic [CODE_W-1:0] code;
      unique case ({row, col})
         4'h0: code = 5'd7;
         4'h1: code = 5'd8;
         4'h2: code = 5'd9;
         4'h3: code = 5'd13;
         4'h4: code = 5'd4;
         4'h5: code = 5'd5;
         4'h6: code = 5'd6;
         4'h7: code = 5'd12;
         4'h8: code = 5'd1;
         4'h9: code = 5'd2;
         4'hA: code = 5'd3;
         4'hB: code = 5'd11;
         4'hC: code = 5'd15;
         4'hD: code = 5'd0;
         4'hE: code = 5'd14;
         default: code = 5'd10;
      endcase
      return code;
   endfunction

endpackage

// ----- rtl/core/mks_step.sv -----
// One tick of the keypad scanner: next scan state and result from the
// current state, the tick's inputs and the wait lengths. Uses mks_pkg.
module mks_step import mks_pkg::*; (
   input  scan_state_type     state_cur,
   input  logic [BTN_W-1:0]   direct_buttons,
   input  logic [COL_W-1:0]   column_lines,
   input  logic [TICK_W-1:0]  debounce_ticks,
   input  logic [TICK_W-1:0]  release_ticks,
   output scan_state_type     state_nxt,
   output result_type         result
);

   logic [TICK_W-1:0] wait_inc;
   logic              debounce_done;
   logic              release_done;
   logic              held_pressed;
   logic              any_button;
   logic [HELD_W-1:0] first_button;
   logic              single_col;
   logic [IDX_W-1:0]  col_idx;
   logic [ROW_W-1:0]  row_mask;

   assign wait_inc      = state_cur.wait_cnt + TICK_W'(1);
   assign debounce_done = (wait_inc >= debounce_ticks);
   assign release_done  = (wait_inc >= release_ticks);
   assign held_pressed  = (state_cur.held != HELD_NONE) && !direct_buttons[state_cur.held];
   assign row_mask      = ROW_W'(1) << state_cur.row;

   always_comb begin
      any_button   = 1'b0;
      first_button = '0;
      for (int i = BTN_W - 1; i >= 0; i--) begin
         if (!direct_buttons[i]) begin
            any_button   = 1'b1;
            first_button = HELD_W'(i);
         end
      end
   end

   always_comb begin
      single_col = 1'b1;
      col_idx    = '0;
      unique case (column_lines)
         4'hE: col_idx = 2'd0;
         4'hD: col_idx = 2'd1;
         4'hB: col_idx = 2'd2;
         4'h7: col_idx = 2'd3;
         default: single_col = 1'b0;
      endcase
   end

   always_comb begin
      state_nxt        = state_cur;
      result.row_drive = state_cur.locked ? '0 : ~row_mask;
      result.key_valid = 1'b0;
      result.key_id    = '0;
      unique case (state_cur.mode)
         MODE_DDEB: begin
            state_nxt.wait_cnt = wait_inc;
            if (debounce_done) begin
               state_nxt.mode = held_pressed ? MODE_DHELD : MODE_IDLE;
            end
         end
         MODE_DHELD: begin
            if (!held_pressed) begin
               result.key_valid = 1'b1;
               result.key_id    = DIRECT_BASE + CODE_W'((state_cur.held != HELD_NONE) ?
                                                        state_cur.held : HELD_LAST);
               state_nxt.mode   = MODE_IDLE;
            end
         end
         MODE_MDEB: begin
            state_nxt.wait_cnt = wait_inc;
            if (debounce_done) begin
               state_nxt.mode = MODE_IDLE;
               if (single_col) begin
                  result.key_valid = 1'b1;
                  result.key_id    = key_lookup(state_cur.row, col_idx);
                  state_nxt.locked = 1'b1;
                  state_nxt.row    = '0;
               end else begin
                  state_nxt.row = state_cur.row + IDX_W'(1);
               end
            end
         end
         MODE_RELWAIT: begin
            state_nxt.wait_cnt = wait_inc;
            if (release_done) begin
               state_nxt.locked = 1'b0;
               state_nxt.row    = '0;
               state_nxt.mode   = MODE_IDLE;
            end
         end
         default: begin
            state_nxt.mode = MODE_IDLE;
            priority if (any_button) begin
               state_nxt.held     = first_button;
               state_nxt.wait_cnt = '0;
               state_nxt.mode     = MODE_DDEB;
            end else if (state_cur.locked) begin
               if (column_lines == COL_IDLE) begin
                  state_nxt.wait_cnt = '0;
                  state_nxt.mode     = MODE_RELWAIT;
               end
            end else if (column_lines != COL_IDLE) begin
               state_nxt.wait_cnt = '0;
               state_nxt.mode     = MODE_MDEB;
            end else begin
               state_nxt.row = state_cur.row + IDX_W'(1);
            end
         end
      endcase
   end

endmodule

// ----- rtl/core/matrix_keypad_scanner_core.sv -----
// Keypad scanner top level: stream ports, wait length registers, scan state
// and result register. Uses mks_pkg and mks_step.
//
// Each request transaction is one scan tick and yields exactly one response
// transaction. A tick is taken in every clock cycle while the response
// register is empty or being drained, so the core sustains one tick per
// cycle; each response is held in the response register. The row_drive
// in a response is the drive that applied during that tick, so column_lines
// of a request must be read back under the row_drive that its own response
// reports. Direct buttons are served first (lowest index wins), debounced and
// reported on release; a debounced single-column matrix hit is reported at
// once and locks the matrix until release_ticks after all columns read high.
module matrix_keypad_scanner_core import mks_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // [6:0] direct_buttons, [10:7] column_lines
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [3:0] row_drive, [4] key_valid, [9:5] key_id
   input  logic              csr_we,
   input  csr_index_type     csr_index,
   input  logic [TICK_W-1:0] csr_wdata
);

   scan_state_type    state_ff, state_in, state_step;
   result_type        result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TICK_W-1:0] debounce_ff, debounce_in;
   logic [TICK_W-1:0] release_ff, release_in;
   logic              req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   mks_step u_step (
      .state_cur      (state_ff),
      .direct_buttons (req_tdata[BTN_W-1:0]),
      .column_lines   (req_tdata[BTN_W+COL_W-1:BTN_W]),
      .debounce_ticks (debounce_ff),
      .release_ticks  (release_ff),
      .state_nxt      (state_step),
      .result         (result_in)
   );

   always_comb begin
      state_in     = req_accept ? state_step : state_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
      debounce_in  = debounce_ff;
      release_in   = release_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            CSR_RELEASE:  release_in  = csr_wdata;
            default:      debounce_in = debounce_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode     <= MODE_IDLE;
         state_ff.row      <= '0;
         state_ff.wait_cnt <= '0;
         state_ff.locked   <= 1'b0;
         state_ff.held     <= '0;
         rsp_valid_ff      <= 1'b0;
         debounce_ff       <= DEBOUNCE_RESET;
         release_ff        <= RELEASE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         debounce_ff  <= debounce_in;
         release_ff   <= release_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - CODE_W - 1 - ROW_W)'(0), result_ff};

   a_locked_drive: assert property (@(posedge clock) disable iff (reset)
      (req_accept && state_ff.locked) |=> (result_ff.row_drive == '0))
      else $error("locked tick did not drive all rows");

   a_single_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.row_drive != '0) |-> ($countones(result_ff.row_drive) == 3))
      else $error("unlocked tick drove other than one row");

   a_lock_on_key: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.locked) |-> (rsp_valid_ff && result_ff.key_valid
                                  && result_ff.key_id < DIRECT_BASE))
      else $error("matrix locked without a matrix key report");

   a_idle_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !result_ff.key_valid) |-> (result_ff.key_id == '0))
      else $error("key code set without a key event");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.key_valid) |-> (result_ff.key_id <= 5'd22))
      else $error("key code out of range");

endmodule

// ----- test/tb_matrix_keypad_scanner_core.sv -----
// Self-checking testbench for matrix_keypad_scanner_core: scan ticks from a
// simulated keypad, a tick-accurate scan predictor and randomised stalls.
// Depends on mks_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_matrix_keypad_scanner_core;
   import mks_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_TICKS = 235;
   localparam int LONG_HOLD   = 600;
   localparam logic [BTN_W-1:0] BTN_NONE = 7'h7F;

   // index {row, col}
   localparam logic [15:0][CODE_W-1:0] KEY_TABLE = {
      5'd10, 5'd14, 5'd0, 5'd15,
      5'd11, 5'd3,  5'd2, 5'd1,
      5'd12, 5'd6,  5'd5, 5'd4,
      5'd13, 5'd9,  5'd8, 5'd7
   };

   localparam scan_state_type SCAN_RESET = '{
      mode: MODE_IDLE, row: '0, wait_cnt: '0, locked: 1'b0, held: '0
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;   // [6:0] direct_buttons, [10:7] column_lines
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;       // [3:0] row_drive, [4] key_valid, [9:5] key_id
   logic              csr_we = 1'b0;
   csr_index_type     csr_index = CSR_DEBOUNCE;
   logic [TICK_W-1:0] csr_wdata = '0;

   matrix_keypad_scanner_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [REQ_W-1:0] tick_queue[$];
   result_type       pending_results[$];
   scan_state_type   plan_state = SCAN_RESET;
   logic [TICK_W-1:0] plan_debounce = DEBOUNCE_RESET;
   logic [TICK_W-1:0] plan_release  = RELEASE_RESET;
   int               ticks_planned = 0;
   int               mismatches = 0;
   int               ticks_checked = 0;
   int               direct_reports = 0;
   int               matrix_reports = 0;
   int               cycles = 0;

   function automatic void scan_tick(input scan_state_type s,
                                     input logic [BTN_W-1:0] btn,
                                     input logic [COL_W-1:0] cols,
                                     input logic [TICK_W-1:0] debounce,
                                     input logic [TICK_W-1:0] release_wait,
                                     output scan_state_type nx,
                                     output result_type res);
      int first;
      int col;
      nx = s;
      res = '0;
      res.row_drive = s.locked ? '0 : ~(4'b0001 << s.row);
      case (s.mode)
         MODE_DDEB: begin
            nx.wait_cnt = s.wait_cnt + 1'b1;
            if (nx.wait_cnt >= debounce)
               nx.mode = btn[s.held] ? MODE_IDLE : MODE_DHELD;
         end
         MODE_DHELD: begin
            if (btn[s.held]) begin
               res.key_valid = 1'b1;
               res.key_id = DIRECT_BASE + CODE_W'(s.held);
               nx.mode = MODE_IDLE;
            end
         end
         MODE_MDEB: begin
            nx.wait_cnt = s.wait_cnt + 1'b1;
            if (nx.wait_cnt >= debounce) begin
               case (cols)
                  4'hE: col = 0;
                  4'hD: col = 1;
                  4'hB: col = 2;
                  4'h7: col = 3;
                  default: col = -1;
               endcase
               if (col >= 0) begin
                  res.key_valid = 1'b1;
                  res.key_id = KEY_TABLE[{s.row, col[1:0]}];
                  nx.locked = 1'b1;
                  nx.row = '0;
               end else begin
                  nx.row = s.row + 1'b1;
               end
               nx.mode = MODE_IDLE;
            end
         end
         MODE_RELWAIT: begin
            nx.wait_cnt = s.wait_cnt + 1'b1;
            if (nx.wait_cnt >= release_wait) begin
               nx.locked = 1'b0;
               nx.row = '0;
               nx.mode = MODE_IDLE;
            end
         end
         default: begin
            nx.mode = MODE_IDLE;
            first = -1;
            for (int i = BTN_W - 1; i >= 0; i--)
               if (!btn[i]) first = i;
            if (first >= 0) begin
               nx.held = first[HELD_W-1:0];
               nx.wait_cnt = '0;
               nx.mode = MODE_DDEB;
            end else if (s.locked) begin
               if (cols == COL_IDLE) begin
                  nx.wait_cnt = '0;
                  nx.mode = MODE_RELWAIT;
               end
            end else if (cols != COL_IDLE) begin
               nx.wait_cnt = '0;
               nx.mode = MODE_MDEB;
            end else begin
               nx.row = s.row + 1'b1;
            end
         end
      endcase
   endfunction

   task automatic push_raw(input logic [BTN_W-1:0] btn, input logic [COL_W-1:0] cols);
      scan_state_type nx;
      result_type res;
      tick_queue.push_back(REQ_W'({cols, btn}));
      scan_tick(plan_state, btn, cols, plan_debounce, plan_release, nx, res);
      plan_state = nx;
      ticks_planned++;
   endtask

   // columns follow the keys held on whichever rows the core drives this tick
   task automatic hold_keys(input logic [BTN_W-1:0] btn, input logic [15:0] keys,
                            input int n);
      logic [ROW_W-1:0] drive;
      logic [COL_W-1:0] cols;
      repeat (n) begin
         drive = plan_state.locked ? '0 : ~(4'b0001 << plan_state.row);
         cols = COL_IDLE;
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               if (!drive[r] && keys[r*4+c]) cols[c] = 1'b0;
         push_raw(btn, cols);
      end
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      $display("mismatch in %s at tick %0d: expected %0d, got %0d",
               field, ticks_checked, want, got);
      mismatches++;
   endtask

   int  gap_left = 0;
   bit  tx_idle = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            req_tdata <= tick_queue.pop_front();
            req_tvalid <= 1'b1;
            gap_left = tx_idle ? $urandom_range(0, 13) : 0;
            if ($urandom_range(0, 99) == 0) tx_idle = !tx_idle;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   int  stall_left = 0;
   int  responses_taken = 0;
   bit  rx_idle = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_taken++;
            if (responses_taken == 400)
               stall_left = LONG_HOLD;
            else
               stall_left = rx_idle ? $urandom_range(0, 13) : 0;
            if ($urandom_range(0, 99) == 0) rx_idle = !rx_idle;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   scan_state_type    scan_state = SCAN_RESET;
   logic [TICK_W-1:0] debounce_reg = DEBOUNCE_RESET;
   logic [TICK_W-1:0] release_reg  = RELEASE_RESET;

   always @(posedge clock) begin
      scan_state_type nx;
      result_type res;
      result_type want;
      if (reset) begin
         scan_state = SCAN_RESET;
         debounce_reg = DEBOUNCE_RESET;
         release_reg = RELEASE_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE: debounce_reg = csr_wdata;
               CSR_RELEASE:  release_reg = csr_wdata;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with nothing pending", 0, 1);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[3:0] !== want.row_drive)
                  report_mismatch("row_drive", int'(want.row_drive), int'(rsp_tdata[3:0]));
               if (rsp_tdata[4] !== want.key_valid)
                  report_mismatch("key_valid", int'(want.key_valid), int'(rsp_tdata[4]));
               if (rsp_tdata[9:5] !== want.key_id)
                  report_mismatch("key_id", int'(want.key_id), int'(rsp_tdata[9:5]));
               if (rsp_tdata[RSP_W-1:10] !== '0)
                  report_mismatch("tdata padding", 0, int'(rsp_tdata[RSP_W-1:10]));
               ticks_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            scan_tick(scan_state, req_tdata[6:0], req_tdata[10:7], debounce_reg,
                      release_reg, nx, res);
            scan_state = nx;
            pending_results.push_back(res);
            if (res.key_valid && res.key_id >= DIRECT_BASE) direct_reports++;
            else if (res.key_valid) matrix_reports++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [TICK_W-1:0] debounce_val;
      logic [TICK_W-1:0] release_val;
      logic [BTN_W-1:0]  btn;
      logic [15:0]       keys;
      int target;
      int kind;
      int eff_deb;
      int eff_rel;
      int n;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         while (tick_queue.size() != 0 || req_tvalid || pending_results.size() != 0)
            @(negedge clock);
         repeat (3) @(posedge clock);
         case (phase)
            0: begin debounce_val = 6'd1;  release_val = 6'd1;  end
            1: begin debounce_val = 6'd2;  release_val = 6'd3;  end
            2: begin debounce_val = 6'd63; release_val = 6'd63; end
            3: begin debounce_val = 6'd0;  release_val = 6'd0;  end
            4: begin
               debounce_val = 6'($urandom_range(1, 8));
               release_val = 6'($urandom_range(1, 8));
            end
            5: begin debounce_val = 6'd25; release_val = 6'd30; end
            6: begin
               debounce_val = 6'($urandom_range(1, 12));
               release_val = 6'($urandom_range(1, 12));
            end
            default: begin debounce_val = 6'd32; release_val = 6'd5; end
         endcase
         csr_we <= 1'b1;
         csr_index <= CSR_DEBOUNCE;
         csr_wdata <= debounce_val;
         @(posedge clock);
         csr_index <= CSR_RELEASE;
         csr_wdata <= release_val;
         @(posedge clock);
         csr_we <= 1'b0;
         plan_debounce = debounce_val;
         plan_release = release_val;
         eff_deb = (debounce_val == 0) ? 1 : debounce_val;
         eff_rel = (release_val == 0) ? 1 : release_val;

         if (phase == 0) begin
            hold_keys(BTN_NONE, 16'h0000, 2);
            // all buttons down, lowest wins; then the last button alone
            hold_keys(7'h00, 16'h0000, 2);
            hold_keys(BTN_NONE, 16'h0000, 1);
            hold_keys(7'h3F, 16'h0000, 2);
            hold_keys(BTN_NONE, 16'h0000, 1);
            // press lost in debounce
            hold_keys(7'h7B, 16'h0000, 1);
            hold_keys(BTN_NONE, 16'h0000, 1);
            // matrix hit and lock, direct button served while locked, unlock
            hold_keys(BTN_NONE, 16'h8000, 6);
            hold_keys(7'h7E, 16'h8000, 2);
            hold_keys(BTN_NONE, 16'h8000, 1);
            hold_keys(BTN_NONE, 16'h0000, 2);
            // two columns on one row
            hold_keys(BTN_NONE, 16'h0090, 5);
            hold_keys(7'h7F, 16'h0000, 1);
            push_raw(7'h00, 4'h0);
         end

         target = ticks_planned + PHASE_TICKS;
         while (ticks_planned < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
               btn = BTN_NONE;
               btn[$urandom_range(0, BTN_W - 1)] = 1'b0;
               if ($urandom_range(0, 3) == 0) btn = btn & 7'($urandom_range(0, 127));
               repeat ($urandom_range(0, 2)) push_raw(7'($urandom_range(0, 127)), COL_IDLE);
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff_deb)
                                               : eff_deb + $urandom_range(1, 4);
               hold_keys(btn, 16'h0000, n);
               hold_keys(BTN_NONE, 16'h0000, $urandom_range(1, 3));
            end else if (kind <= 6) begin
               keys = 16'h0001 << $urandom_range(0, 15);
               if ($urandom_range(0, 4) == 0) keys = keys | (16'h0001 << $urandom_range(0, 15));
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff_deb + 3)
                                               : eff_deb + $urandom_range(4, 8);
               hold_keys(BTN_NONE, keys, n);
               if ($urandom_range(0, 5) == 0) begin
                  btn = BTN_NONE;
                  btn[$urandom_range(0, BTN_W - 1)] = 1'b0;
                  hold_keys(btn, keys, eff_deb + $urandom_range(1, 3));
                  hold_keys(BTN_NONE, keys, 1);
               end
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff_rel)
                                               : eff_rel + $urandom_range(1, 3);
               hold_keys(BTN_NONE, 16'h0000, n);
            end else if (kind == 7) begin
               repeat ($urandom_range(1, 4))
                  push_raw(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
            end else if (kind == 8) begin
               hold_keys(BTN_NONE, 16'h0000, $urandom_range(1, 6));
            end else begin
               hold_keys(BTN_NONE, 16'($urandom_range(0, 65535)), $urandom_range(1, 6));
               hold_keys(BTN_NONE, 16'h0000, $urandom_range(1, 3));
            end
         end
      end

      while (tick_queue.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (ticks_checked != ticks_planned)
         report_mismatch("ticks checked", ticks_planned, ticks_checked);
      $display("checked %0d scan ticks over %0d register settings", ticks_checked, PHASES);
      $display("reported %0d direct button and %0d matrix key events",
               direct_reports, matrix_reports);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/mks_pkg.sv
rtl/core/mks_step.sv
rtl/core/matrix_keypad_scanner_core.sv
test/tb_matrix_keypad_scanner_core.sv
